// ===== rtl/laau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laau_pkg
// Shared types, constants and helpers for the load accumulator addressing unit.
// ----------------------------------------------------------------------------
package laau_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int WORD_BITS         = 16;
    localparam int BYTE_BITS         = 8;

    localparam logic [7:0]  ZERO_FLAG = 8'h02;
    localparam logic [7:0]  NEG_FLAG  = 8'h80;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;
    localparam logic [15:0] PAGE_MASK = 16'hFF00;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EXEC  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IMM  = 3'd0,
        MODE_ZP   = 3'd1,
        MODE_ZPX  = 3'd2,
        MODE_ABS  = 3'd3,
        MODE_ABSX = 3'd4,
        MODE_ABSY = 3'd5,
        MODE_INDX = 3'd6,
        MODE_INDY = 3'd7
    } mode_t;

    // Memory port request: one access per cycle, read data registered
    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [WORD_BITS-1:0] addr;
        logic [BYTE_BITS-1:0] wdata;
    } mem_req_t;

    // Instruction cycle count before any page-crossing penalty
    function automatic logic [2:0] base_cycles(input mode_t m);
        logic [2:0] c;
        begin
            case (m)
                MODE_IMM:  c = 3'd2;
                MODE_ZP:   c = 3'd3;
                MODE_ZPX:  c = 3'd4;
                MODE_ABS:  c = 3'd4;
                MODE_ABSX: c = 3'd4;
                MODE_ABSY: c = 3'd4;
                MODE_INDX: c = 3'd6;
                MODE_INDY: c = 3'd5;
                default:   c = 3'd2;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/laau_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laau_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module laau_mem #(
    parameter int ADDR_BITS = laau_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                clk,
    input  laau_pkg::mem_req_t                  req,
    output logic [laau_pkg::BYTE_BITS-1:0]      rdata
);

    logic [laau_pkg::BYTE_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [ADDR_BITS-1:0]           addr;

    // Only the low address bits select a byte, so the space aliases
    assign addr = req.addr[ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/laau_addr_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laau_addr_unit
// Shared 16-bit address adder with page-crossing detect.
// ----------------------------------------------------------------------------
module laau_addr_unit (
    input  logic [laau_pkg::WORD_BITS-1:0] a,
    input  logic [laau_pkg::WORD_BITS-1:0] b,
    output logic [laau_pkg::WORD_BITS-1:0] sum,
    output logic                           page_cross
);

    // Sum wraps at 16 bits
    assign sum        = a + b;
    assign page_cross = (a & laau_pkg::PAGE_MASK) != (sum & laau_pkg::PAGE_MASK);

endmodule

// ===== rtl/load_accumulator_addressing_unit.sv =====
`timescale 1ns / 1ps
// A write transfer gives no result. A load steps from input transfer to result
// valid through S_OP0, then S_OP1 (absolute modes) or S_PLO and S_PHI (indirect
// modes), then S_VAL (all but immediate) and S_FIN, which forms the result;
// dependent reads share the single memory port. Input is ready again as the
// result goes valid, so a new transfer waits for the last load; a full output
// register holds the last step. Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// load_accumulator_addressing_unit
// Byte memory plus a sequencer that walks the load addressing modes over a
// shared address adder and one memory port.
// ----------------------------------------------------------------------------
module load_accumulator_addressing_unit #(
    parameter int ADDR_BITS = laau_pkg::ADDR_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [2:0]  mode,
    input  logic [15:0] write_address,
    input  logic [7:0]  write_data,
    input  logic [15:0] pc_in,
    input  logic [7:0]  index_x,
    input  logic [7:0]  index_y,
    input  logic [7:0]  status_in,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  accumulator,
    output logic [7:0]  status_out,
    output logic [15:0] pc_next,
    output logic [2:0]  cycles_taken
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP0  = 7'b0000010,
        S_OP1  = 7'b0000100,
        S_PLO  = 7'b0001000,
        S_PHI  = 7'b0010000,
        S_VAL  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    laau_pkg::mode_t mode_reg;
    logic [15:0]     pc_reg;
    logic [7:0]      x_reg;
    logic [7:0]      y_reg;
    logic [7:0]      p_reg;
    logic [7:0]      op0_reg;
    logic [7:0]      ptr_reg, ptr_next;
    logic [7:0]      lo_reg;
    logic [7:0]      val_reg;
    logic            cross_reg, cross_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      acc_reg;
    logic [7:0]      status_reg;
    logic [15:0]     pc_out_reg;
    logic [2:0]      cyc_reg;

    laau_pkg::mem_req_t mem_req;
    logic [7:0]         rdata;
    logic [15:0]        add_a, add_b, add_sum;
    logic               add_cross;
    logic               in_xfer;
    logic               out_free;
    logic               abs_mode;

    laau_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    laau_addr_unit u_addr (
        .a          (add_a),
        .b          (add_b),
        .sum        (add_sum),
        .page_cross (add_cross)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign abs_mode = (mode_reg == laau_pkg::MODE_ABS) || (mode_reg == laau_pkg::MODE_ABSX)
                   || (mode_reg == laau_pkg::MODE_ABSY);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cross_next    = cross_reg;
        add_a         = 16'h0000;
        add_b         = 16'h0000;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = pc_reg;
        mem_req.wdata = write_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mem_req.en = 1'b1;
                    if (command == laau_pkg::CMD_WRITE)
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = write_address;
                    end
                    else
                    begin
                        // Fetch the first operand byte straight away
                        mem_req.addr = pc_in;
                        cross_next   = 1'b0;
                        state_next   = S_OP0;
                    end
                end
            end
            S_OP0:
            begin
                case (mode_reg)
                    laau_pkg::MODE_IMM:
                    begin
                        state_next = S_FIN;
                    end
                    laau_pkg::MODE_ZP:
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = {8'h00, rdata};
                        state_next   = S_VAL;
                    end
                    laau_pkg::MODE_ZPX:
                    begin
                        add_a        = {8'h00, rdata};
                        add_b        = {8'h00, x_reg};
                        mem_req.en   = 1'b1;
                        mem_req.addr = {8'h00, add_sum[7:0]};
                        state_next   = S_VAL;
                    end
                    laau_pkg::MODE_ABS, laau_pkg::MODE_ABSX, laau_pkg::MODE_ABSY:
                    begin
                        add_a        = pc_reg;
                        add_b        = 16'h0001;
                        mem_req.en   = 1'b1;
                        mem_req.addr = add_sum;
                        state_next   = S_OP1;
                    end
                    laau_pkg::MODE_INDX:
                    begin
                        add_a        = {8'h00, rdata};
                        add_b        = {8'h00, x_reg};
                        ptr_next     = add_sum[7:0];
                        mem_req.en   = 1'b1;
                        mem_req.addr = {8'h00, add_sum[7:0]};
                        state_next   = S_PLO;
                    end
                    laau_pkg::MODE_INDY:
                    begin
                        ptr_next     = rdata;
                        mem_req.en   = 1'b1;
                        mem_req.addr = {8'h00, rdata};
                        state_next   = S_PLO;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_OP1:
            begin
                add_a = {rdata, op0_reg};
                if (mode_reg == laau_pkg::MODE_ABSX)
                begin
                    add_b = {8'h00, x_reg};
                end
                else if (mode_reg == laau_pkg::MODE_ABSY)
                begin
                    add_b = {8'h00, y_reg};
                end
                cross_next   = add_cross;
                mem_req.en   = 1'b1;
                mem_req.addr = add_sum;
                state_next   = S_VAL;
            end
            S_PLO:
            begin
                // Pointer high byte wraps within page zero
                add_a        = {8'h00, ptr_reg};
                add_b        = 16'h0001;
                mem_req.en   = 1'b1;
                mem_req.addr = {8'h00, add_sum[7:0]};
                state_next   = S_PHI;
            end
            S_PHI:
            begin
                add_a = {rdata, lo_reg};
                if (mode_reg == laau_pkg::MODE_INDY)
                begin
                    add_b = {8'h00, y_reg};
                end
                cross_next   = add_cross;
                mem_req.en   = 1'b1;
                mem_req.addr = add_sum;
                state_next   = S_VAL;
            end
            S_VAL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                add_a = pc_reg;
                add_b = abs_mode ? 16'h0002 : 16'h0001;
                // Hold until the output register is free
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cross_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cross_reg     <= cross_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (in_xfer)
        begin
            mode_reg <= laau_pkg::mode_t'(mode);
            pc_reg   <= pc_in;
            x_reg    <= index_x;
            y_reg    <= index_y;
            p_reg    <= status_in;
        end
        if (state_reg == S_OP0)
        begin
            op0_reg <= rdata;
            val_reg <= rdata;
        end
        if (state_reg == S_PLO)
        begin
            lo_reg <= rdata;
        end
        if (state_reg == S_VAL)
        begin
            val_reg <= rdata;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            acc_reg    <= val_reg;
            status_reg <= (p_reg & ~(laau_pkg::ZERO_FLAG | laau_pkg::NEG_FLAG))
                        | ((val_reg == 8'h00) ? laau_pkg::ZERO_FLAG : 8'h00)
                        | (val_reg & laau_pkg::NEG_FLAG);
            pc_out_reg <= add_sum;
            cyc_reg    <= laau_pkg::base_cycles(mode_reg) + {2'b00, cross_reg};
        end
    end

    assign out_valid    = out_valid_reg;
    assign accumulator  = acc_reg;
    assign status_out   = status_reg;
    assign pc_next      = pc_out_reg;
    assign cycles_taken = cyc_reg;

endmodule

// ===== bench/load_accumulator_addressing_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_accumulator_addressing_unit_tb
// Checks every load addressing mode against a predictor with its own memory
// image. Fresh loads first write operand, pointer and target bytes, and any
// other unwritten byte read is filled, so no load reads memory never written.
// Directed corner cases come first, then random well-formed loads mixed with
// stray writes and bare loads, under changing idle rates on both channels.
// ----------------------------------------------------------------------------
module load_accumulator_addressing_unit_tb;

    localparam int          ADDR_BITS    = laau_pkg::ADDR_BITS_DEFAULT;
    localparam int          MEM_DEPTH    = 1 << ADDR_BITS;
    localparam logic [15:0] ADDR_MASK    = 16'(MEM_DEPTH - 1);
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  status;
        logic [15:0] pc;
        logic [2:0]  cycles;
    } load_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [2:0]  mode;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] pc_in;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  status_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  accumulator;
    logic [7:0]  status_out;
    logic [15:0] pc_next;
    logic [2:0]  cycles_taken;

    bit [7:0]     mem_image   [0:MEM_DEPTH-1];
    bit           mem_written [0:MEM_DEPTH-1];
    load_result_t load_results_due[$];
    load_result_t head_result;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off      = 0;
    int          items_sent    = 0;
    int          mismatches    = 0;
    int unsigned cycle_count   = 0;

    load_accumulator_addressing_unit #(
        .ADDR_BITS(ADDR_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .mode         (mode),
        .write_address(write_address),
        .write_data   (write_data),
        .pc_in        (pc_in),
        .index_x      (index_x),
        .index_y      (index_y),
        .status_in    (status_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accumulator  (accumulator),
        .status_out   (status_out),
        .pc_next      (pc_next),
        .cycles_taken (cycles_taken)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: a long hold-off counts down here, otherwise stall at random
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off = hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Memory byte as the block sees it; note the first read of an unwritten cell
    function automatic logic [7:0] peek(input logic [15:0] addr, inout bit hit_gap,
                                        inout logic [15:0] gap_addr);
        if (!mem_written[addr & ADDR_MASK] && !hit_gap)
        begin
            hit_gap  = 1'b1;
            gap_addr = addr;
        end
        return mem_image[addr & ADDR_MASK];
    endfunction

    // Work out the result of one load from the memory image. Returns 0 and the
    // offending address when the load would touch a byte never written.
    function automatic bit predict_load(input laau_pkg::mode_t m, input logic [15:0] pc,
                                        input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] p, output load_result_t r,
                                        output logic [15:0] ea, output logic [15:0] zp,
                                        output logic [15:0] gap_addr);
        bit          hit_gap;
        logic [7:0]  op0, op1, lo, hi, zp_lo, idx, val;
        logic [15:0] base, len;
        logic [2:0]  cyc;
        hit_gap  = 1'b0;
        gap_addr = 16'h0000;
        op0  = peek(pc, hit_gap, gap_addr);
        op1  = peek(pc + 16'd1, hit_gap, gap_addr);
        zp   = pc;
        ea   = 16'h0000;
        len  = 16'd1;
        cyc  = 3'd2;
        case (m)
            laau_pkg::MODE_ZP:
            begin
                ea  = {8'h00, op0};
                cyc = 3'd3;
            end
            laau_pkg::MODE_ZPX:
            begin
                ea  = {8'h00, 8'(op0 + x)};
                cyc = 3'd4;
            end
            laau_pkg::MODE_ABS:
            begin
                ea  = {op1, op0};
                len = 16'd2;
                cyc = 3'd4;
            end
            laau_pkg::MODE_ABSX, laau_pkg::MODE_ABSY:
            begin
                if (m == laau_pkg::MODE_ABSX)
                    idx = x;
                else
                    idx = y;
                base = {op1, op0};
                ea   = base + {8'h00, idx};
                len  = 16'd2;
                cyc  = (base[15:8] != ea[15:8]) ? 3'd5 : 3'd4;
            end
            laau_pkg::MODE_INDX:
            begin
                zp_lo = 8'(op0 + x);
                zp    = {8'h00, zp_lo};
                lo    = peek({8'h00, zp_lo}, hit_gap, gap_addr);
                hi    = peek({8'h00, 8'(zp_lo + 8'd1)}, hit_gap, gap_addr);
                ea    = {hi, lo};
                cyc   = 3'd6;
            end
            laau_pkg::MODE_INDY:
            begin
                zp    = {8'h00, op0};
                lo    = peek({8'h00, op0}, hit_gap, gap_addr);
                hi    = peek({8'h00, 8'(op0 + 8'd1)}, hit_gap, gap_addr);
                base  = {hi, lo};
                ea    = base + {8'h00, y};
                cyc   = (base[15:8] != ea[15:8]) ? 3'd6 : 3'd5;
            end
            default:
                ea = 16'h0000;
        endcase
        if (m == laau_pkg::MODE_IMM)
            val = op0;
        else
            val = peek(ea, hit_gap, gap_addr);
        r.acc    = val;
        r.status = (p & ~(laau_pkg::ZERO_FLAG | laau_pkg::NEG_FLAG))
                 | (val & laau_pkg::NEG_FLAG);
        if (val == 8'h00)
            r.status = r.status | laau_pkg::ZERO_FLAG;
        r.pc     = pc + len;
        r.cycles = cyc;
        return !hit_gap;
    endfunction

    // One transfer on the input channel; update the memory image or queue the
    // expected load result at the edge where it is accepted
    task automatic send_item(input logic cmd, input laau_pkg::mode_t m,
                             input logic [15:0] waddr, input logic [7:0] wdata,
                             input logic [15:0] pc, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] p);
        load_result_t r;
        logic [15:0]  ea, zp, gap;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command       <= cmd;
        mode          <= m;
        write_address <= waddr;
        write_data    <= wdata;
        pc_in         <= pc;
        index_x       <= x;
        index_y       <= y;
        status_in     <= p;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == laau_pkg::CMD_WRITE)
        begin
            mem_image[waddr & ADDR_MASK]   = wdata;
            mem_written[waddr & ADDR_MASK] = 1'b1;
        end
        else
        begin
            void'(predict_load(m, pc, x, y, p, r, ea, zp, gap));
            load_results_due.push_back(r);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
        send_item(laau_pkg::CMD_WRITE, laau_pkg::mode_t'($urandom_range(7)), addr, data,
                  16'($urandom_range(65535)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Lay down operand, pointer and target bytes (when fresh), fill any byte
    // still unwritten that the load reads, then issue the load
    task automatic load_with(input laau_pkg::mode_t m, input logic [15:0] pc,
                             input logic [7:0] op0, input logic [7:0] op1,
                             input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] p, input logic [7:0] data, input bit fresh,
                             input logic [15:0] ptr);
        load_result_t r;
        logic [15:0]  ea, zp, gap;
        logic [7:0]   zp_lo;
        if (fresh)
        begin
            write_byte(pc, op0);
            write_byte(pc + 16'd1, op1);
            if (m == laau_pkg::MODE_INDX || m == laau_pkg::MODE_INDY)
            begin
                zp_lo = (m == laau_pkg::MODE_INDX) ? 8'(op0 + x) : op0;
                write_byte({8'h00, zp_lo}, ptr[7:0]);
                write_byte({8'h00, 8'(zp_lo + 8'd1)}, ptr[15:8]);
            end
        end
        while (!predict_load(m, pc, x, y, p, r, ea, zp, gap))
            write_byte(gap, 8'($urandom_range(255)));
        // Leave the target alone where it shares a byte with an operand or pointer
        if (fresh && m != laau_pkg::MODE_IMM && ea != pc && ea != pc + 16'd1 && ea != zp
            && ea != {8'h00, 8'(zp[7:0] + 8'd1)})
            write_byte(ea, data);
        send_item(laau_pkg::CMD_EXEC, m, 16'($urandom_range(65535)),
                  8'($urandom_range(255)), pc, x, y, p);
    endtask

    task automatic random_load(input bit fresh);
        laau_pkg::mode_t m;
        logic [15:0]     pc;
        logic [7:0]      x, y, data;
        m = laau_pkg::mode_t'($urandom_range(7));
        case ($urandom_range(7))
            0:       pc = 16'hFFFF;
            1:       pc = 16'($urandom_range(255));
            default: pc = 16'($urandom_range(65535));
        endcase
        x = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            x = {8{x[0]}};
        y = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            y = {8{y[0]}};
        data = 8'($urandom_range(255));
        if ($urandom_range(7) == 0)
            data = 8'h00;
        load_with(m, pc, 8'($urandom_range(255)), 8'($urandom_range(255)), x, y,
                  8'($urandom_range(255)), data, fresh, 16'($urandom_range(65535)));
    endtask

    // Stop offering transfers until every expected result has arrived
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (load_results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (load_results_due.size() == 0)
            begin
                $display("%0t: result with no load outstanding: expected none, actual %h %h",
                         $time, accumulator, pc_next);
                mismatches++;
            end
            else
            begin
                head_result = load_results_due.pop_front();
                check_field("accumulator", 16'(head_result.acc), 16'(accumulator));
                check_field("status_out", 16'(head_result.status), 16'(status_out));
                check_field("pc_next", head_result.pc, pc_next);
                check_field("cycles_taken", 16'(head_result.cycles), 16'(cycles_taken));
            end
        end
    end

    task automatic test_immediate_flags();
        load_with(laau_pkg::MODE_IMM, 16'h0200, 8'h00, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h00,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_IMM, 16'h0210, 8'h80, 8'hA5, 8'hFF, 8'hFF, 8'h00, 8'h00,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_IMM, 16'h0220, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h82, 8'h00,
                  1'b1, 16'h0);
        // pc at the top of memory: second operand byte comes from 0x0000
        load_with(laau_pkg::MODE_IMM, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  1'b1, 16'h0);
        wait_for_results();
    endtask

    task automatic test_zero_page_wrap();
        load_with(laau_pkg::MODE_ZP,  16'h0400, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'hFF,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ZP,  16'h0410, 8'hFF, 8'h22, 8'h00, 8'h00, 8'hFF, 8'h01,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ZPX, 16'h0420, 8'hF0, 8'h33, 8'h20, 8'h00, 8'h00, 8'h80,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ZPX, 16'h0430, 8'hFF, 8'h44, 8'hFF, 8'h00, 8'h7D, 8'h00,
                  1'b1, 16'h0);
        wait_for_results();
    endtask

    task automatic test_absolute_paging();
        load_with(laau_pkg::MODE_ABS,  16'hFFFF, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 8'h99,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ABSX, 16'h0500, 8'hF0, 8'h12, 8'h0F, 8'h00, 8'h00, 8'h5C,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ABSX, 16'h0510, 8'hF0, 8'h12, 8'h10, 8'h00, 8'hFF, 8'hC5,
                  1'b1, 16'h0);
        // base at 0xFFFF plus one wraps to 0x0000 and crosses a page
        load_with(laau_pkg::MODE_ABSY, 16'h0520, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00,
                  1'b1, 16'h0);
        load_with(laau_pkg::MODE_ABSY, 16'h0530, 8'h00, 8'h30, 8'h00, 8'hFF, 8'h00, 8'h81,
                  1'b1, 16'h0);
        wait_for_results();
    endtask

    task automatic test_indirect_pointers();
        // pointer high byte at 0xFF + 1 comes from 0x00
        load_with(laau_pkg::MODE_INDX, 16'h0600, 8'hFE, 8'h00, 8'h01, 8'h00, 8'h00, 8'h6E,
                  1'b1, 16'h4567);
        load_with(laau_pkg::MODE_INDX, 16'h0610, 8'h10, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                  1'b1, 16'hFFFF);
        load_with(laau_pkg::MODE_INDX, 16'h0620, 8'h80, 8'h00, 8'hC0, 8'h00, 8'h00, 8'hF0,
                  1'b1, 16'h0700);
        load_with(laau_pkg::MODE_INDY, 16'h0630, 8'hFF, 8'h00, 8'h00, 8'h20, 8'h00, 8'h42,
                  1'b1, 16'h12F0);
        load_with(laau_pkg::MODE_INDY, 16'h0640, 8'h40, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h90,
                  1'b1, 16'h5000);
        load_with(laau_pkg::MODE_INDY, 16'h0650, 8'h41, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h07,
                  1'b1, 16'hFFFF);
        wait_for_results();
    endtask

    task automatic test_random_loads(input int n_items, input int send_pct, input int recv_pct);
        int start;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(19);
            if (pick < 2)
                write_byte(16'($urandom_range(65535)), 8'($urandom_range(255)));
            else if (pick < 4)
                random_load(1'b0);
            else if (pick == 4)
                wait_for_results();
            else
                random_load(1'b1);
        end
        wait_for_results();
    endtask

    // Hold the output off while loads keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 300;
        repeat (12) random_load(1'b1);
        wait_for_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        command       = laau_pkg::CMD_WRITE;
        mode          = laau_pkg::MODE_IMM;
        write_address = 16'h0000;
        write_data    = 8'h00;
        pc_in         = 16'h0000;
        index_x       = 8'h00;
        index_y       = 8'h00;
        status_in     = 8'h00;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 69;
        test_immediate_flags();
        test_zero_page_wrap();
        test_absolute_paging();
        test_indirect_pointers();
        test_random_loads(140, 16, 69);
        test_random_loads(140, 69, 16);
        test_random_loads(140, 0, 0);
        test_output_backpressure();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/laau_pkg.sv
rtl/laau_mem.sv
rtl/laau_addr_unit.sv
rtl/load_accumulator_addressing_unit.sv
bench/load_accumulator_addressing_unit_tb.sv
